// File: hdl/rca_pkg.sv
package rca_pkg;

   localparam int FUNC_W   = 2;
   localparam int COUNT_W  = 7;
   localparam int CORE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int BCNT_W   = 8;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CORE_W-1:0]   core_type;
   typedef logic [BCNT_W-1:0]   bcnt_type;

   localparam func_type FUNC_ALLOC   = 2'd0;
   localparam func_type FUNC_BIND    = 2'd1;
   localparam func_type FUNC_RELEASE = 2'd2;
   localparam func_type FUNC_CLEAR   = 2'd3;

   localparam status_type ST_GRANT = 2'd0;
   localparam status_type ST_SHORT = 2'd1;
   localparam status_type ST_ACK   = 2'd2;

   localparam bcnt_type  BCNT_MAX   = 8'd255;
   localparam count_type INDEX_SPAN = 7'd64;
   localparam count_type CORES_RST  = 7'd64;

endpackage

// File: hdl/rca_req_if.sv
interface rca_req_if;
   logic                valid;
   logic                ready;
   rca_pkg::func_type   func;
   rca_pkg::count_type  count;
   rca_pkg::core_type   core;

   modport source (output valid, output func, output count, output core, input ready);
   modport sink   (input valid, input func, input count, input core, output ready);
endinterface

// File: hdl/rca_rsp_if.sv
interface rca_rsp_if;
   logic                valid;
   logic                ready;
   rca_pkg::status_type status;
   rca_pkg::core_type   core_res;
   logic                last;

   modport source (output valid, output status, output core_res, output last, input ready);
   modport sink   (input valid, input status, input core_res, input last, output ready);
endinterface

// File: hdl/rca_ram.sv
module rca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_W-1:0]     waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [ADDR_W-1:0]     raddr,
   output logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/refcounted_core_allocator.sv
// Core allocator with one 8-bit binding count per core, held in a single-port-read RAM.
// One transaction is handled at a time; req_ch.ready is high only while the sequencer is idle.
// An allocate reads one count per cycle through the RAM read port, held while the result
// channel stalls a grant: a counting pass over cores 0 to limit-1, then a grant pass that
// rescans them and grants free cores in order. A short allocate answers after the counting
// pass; a zero-core allocate answers at once. Bind, release and release-with-reset take a
// read-modify-write, then hand the acknowledgment to the output register; a core at or
// above limit is acknowledged with no write. Counts read as zero until a core is first
// written (one flip-flop valid bit per core), so no clearing pass follows reset.
// limit is the smallest of cores_present, MAX_CORES and 64.
module refcounted_core_allocator #(
   parameter int MAX_CORES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [6:0]              csr_wdata,
   rca_req_if.sink                 req_ch,
   rca_rsp_if.source               rsp_ch
);
   localparam int ADDR_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int SPAN_I = (MAX_CORES < 64) ? MAX_CORES : 64;
   localparam rca_pkg::count_type SPAN = rca_pkg::COUNT_W'(SPAN_I);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_COUNT  = 3'd1;
   localparam logic [2:0] S_GRANT  = 3'd2;
   localparam logic [2:0] S_RMW_RD = 3'd3;
   localparam logic [2:0] S_RMW_WR = 3'd4;
   localparam logic [2:0] S_REPLY  = 3'd5;

   logic [2:0]              state_ff, state_in;
   rca_pkg::count_type      cores_ff;
   rca_pkg::count_type      limit;
   rca_pkg::count_type      issue_ff, issue_in;
   logic                    p_vld_ff, p_vld_in;
   rca_pkg::core_type       p_idx_ff, p_idx_in;
   rca_pkg::count_type      nfree_ff, nfree_in;
   rca_pkg::count_type      k_ff, k_in;
   rca_pkg::count_type      want_ff, want_in;
   rca_pkg::core_type       core_ff, core_in;
   rca_pkg::func_type       func_ff, func_in;
   rca_pkg::status_type     reply_ff, reply_in;
   logic [MAX_CORES-1:0]    valid_ff, valid_in;
   logic                    rd_vld_ff;

   logic                    out_vld_ff, out_vld_in;
   rca_pkg::status_type     out_status_ff, out_status_in;
   rca_pkg::core_type       out_core_ff, out_core_in;
   logic                    out_last_ff, out_last_in;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   rca_pkg::bcnt_type       ram_wdata, ram_rdata;
   rca_pkg::bcnt_type       cur_cnt;
   logic                    entry_free;
   logic                    out_free;
   logic                    req_take;
   logic                    grant_load;
   logic                    grant_last;
   logic                    stall;

   assign limit      = (cores_ff < SPAN) ? cores_ff : SPAN;
   assign cur_cnt    = rd_vld_ff ? ram_rdata : '0;
   assign entry_free = (cur_cnt == '0);
   assign out_free   = !out_vld_ff || rsp_ch.ready;
   assign req_take   = req_ch.valid && req_ch.ready;

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.status   = out_status_ff;
   assign rsp_ch.core_res = out_core_ff;
   assign rsp_ch.last     = out_last_ff;

   assign stall      = p_vld_ff && entry_free && !out_free;
   assign grant_load = (state_ff == S_GRANT) && p_vld_ff && entry_free && out_free;
   assign grant_last = (k_ff + 7'd1 == want_ff);

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      p_vld_in      = p_vld_ff;
      p_idx_in      = p_idx_ff;
      nfree_in      = nfree_ff;
      k_in          = k_ff;
      want_in       = want_ff;
      core_in       = core_ff;
      func_in       = func_ff;
      reply_in      = reply_ff;
      valid_in      = valid_ff;
      out_vld_in    = out_vld_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_core_in   = out_core_ff;
      out_last_in   = out_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = ADDR_W'(core_ff);
      ram_raddr     = ADDR_W'(issue_ff);
      ram_wdata     = cur_cnt;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               want_in  = req_ch.count;
               core_in  = req_ch.core;
               func_in  = req_ch.func;
               issue_in = '0;
               p_vld_in = 1'b0;
               nfree_in = '0;
               k_in     = '0;
               reply_in = rca_pkg::ST_ACK;
               if (req_ch.func == rca_pkg::FUNC_ALLOC) begin
                  state_in = (req_ch.count == '0) ? S_REPLY : S_COUNT;
               end else if (rca_pkg::COUNT_W'(req_ch.core) < limit) begin
                  state_in = S_RMW_RD;
               end else begin
                  state_in = S_REPLY;
               end
            end
         end
         S_COUNT: begin
            if (p_vld_ff && entry_free) begin
               nfree_in = nfree_ff + 7'd1;
            end
            if (issue_ff < limit) begin
               ram_re   = 1'b1;
               p_vld_in = 1'b1;
               p_idx_in = issue_ff[rca_pkg::CORE_W-1:0];
               issue_in = issue_ff + 7'd1;
            end else begin
               p_vld_in = 1'b0;
               if (!p_vld_ff) begin
                  // counting pass drained: decide on the final tally
                  if (nfree_ff < want_ff) begin
                     reply_in = rca_pkg::ST_SHORT;
                     state_in = S_REPLY;
                  end else begin
                     issue_in = '0;
                     state_in = S_GRANT;
                  end
               end
            end
         end
         S_GRANT: begin
            if (grant_load) begin
               out_vld_in    = 1'b1;
               out_status_in = rca_pkg::ST_GRANT;
               out_core_in   = p_idx_ff;
               out_last_in   = grant_last;
               k_in          = k_ff + 7'd1;
            end
            if (grant_load && grant_last) begin
               p_vld_in = 1'b0;
               state_in = S_IDLE;
            end else if (!stall) begin
               // hold the RAM output while a grant waits for the output register
               if (issue_ff < limit) begin
                  ram_re   = 1'b1;
                  p_vld_in = 1'b1;
                  p_idx_in = issue_ff[rca_pkg::CORE_W-1:0];
                  issue_in = issue_ff + 7'd1;
               end else begin
                  p_vld_in = 1'b0;
               end
            end
         end
         S_RMW_RD: begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(core_ff);
            state_in  = S_RMW_WR;
         end
         S_RMW_WR: begin
            case (func_ff)
               rca_pkg::FUNC_BIND: begin
                  ram_wdata = (cur_cnt == rca_pkg::BCNT_MAX) ? cur_cnt : cur_cnt + 8'd1;
               end
               rca_pkg::FUNC_RELEASE: begin
                  ram_wdata = (cur_cnt == '0) ? cur_cnt : cur_cnt - 8'd1;
               end
               default: begin
                  ram_wdata = '0;
               end
            endcase
            ram_we                      = 1'b1;
            valid_in[ADDR_W'(core_ff)]  = 1'b1;
            state_in                    = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               out_vld_in    = 1'b1;
               out_status_in = reply_ff;
               out_core_in   = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cores_ff   <= rca_pkg::CORES_RST;
         valid_ff   <= '0;
         out_vld_ff <= 1'b0;
         p_vld_ff   <= 1'b0;
         issue_ff   <= '0;
         nfree_ff   <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         out_vld_ff <= out_vld_in;
         p_vld_ff   <= p_vld_in;
         issue_ff   <= issue_in;
         nfree_ff   <= nfree_in;
         k_ff       <= k_in;
         if (csr_we) begin
            cores_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff      <= p_idx_in;
      want_ff       <= want_in;
      core_ff       <= core_in;
      func_ff       <= func_in;
      reply_ff      <= reply_in;
      out_status_ff <= out_status_in;
      out_core_ff   <= out_core_in;
      out_last_ff   <= out_last_in;
      if (ram_re) begin
         rd_vld_ff <= valid_ff[ram_raddr];
      end
   end

   rca_ram #(
      .WIDTH (rca_pkg::BCNT_W),
      .DEPTH (MAX_CORES)
   ) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after taking a request");

   a_nfree_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COUNT) |-> (nfree_ff <= issue_ff))
      else $error("free tally exceeds cores scanned");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      grant_load |-> (rca_pkg::COUNT_W'(p_idx_ff) < limit) && (k_ff < want_ff))
      else $error("grant beyond limit or beyond requested count");

   a_grant_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_GRANT) && stall) |=> $stable(p_idx_ff) && $stable(k_ff))
      else $error("grant pipeline moved during output stall");

endmodule

// File: tb/refcounted_core_allocator_tb.sv
`timescale 1ns / 100ps

module refcounted_core_allocator_tb;
   import rca_pkg::*;

   localparam int CORE_SLOTS = 64;

   typedef struct packed {
      status_type status;
      core_type   core_res;
      logic       last;
   } grant_rsp_type;

   class core_alloc_scoreboard;
      bcnt_type      bind_cnt [CORE_SLOTS];
      count_type     cores_present;
      grant_rsp_type rsp_q [$];
      int            errors;

      function new();
         foreach (bind_cnt[i]) bind_cnt[i] = '0;
         cores_present = CORES_RST;
         errors = 0;
      endfunction

      function void set_cores(count_type v);
         cores_present = v;
      endfunction

      function int active_limit();
         int n;
         n = cores_present;
         if (n > CORE_SLOTS) n = CORE_SLOTS;
         if (n > INDEX_SPAN) n = INDEX_SPAN;
         return n;
      endfunction

      function int pending_count();
         return rsp_q.size();
      endfunction

      function void push_rsp(status_type s, core_type c, logic l);
         grant_rsp_type r;
         r.status = s;
         r.core_res = c;
         r.last = l;
         rsp_q.push_back(r);
      endfunction

      // Work out the responses one accepted request transaction causes.
      function void note_request(func_type f, count_type want, core_type c);
         int lim;
         int nfree;
         int k;
         lim = active_limit();
         if (f == FUNC_ALLOC) begin
            if (want == 0) begin
               push_rsp(ST_ACK, '0, 1'b1);
               return;
            end
            nfree = 0;
            for (int i = 0; i < lim; i++)
               if (bind_cnt[i] == 0) nfree++;
            if (nfree < want) begin
               push_rsp(ST_SHORT, '0, 1'b1);
               return;
            end
            k = 0;
            for (int i = 0; i < lim && k < want; i++) begin
               if (bind_cnt[i] == 0) begin
                  push_rsp(ST_GRANT, core_type'(i), (k + 1 == want));
                  k++;
               end
            end
            return;
         end
         if (c < lim) begin
            case (f)
               FUNC_BIND: begin
                  if (bind_cnt[c] != BCNT_MAX) bind_cnt[c]++;
               end
               FUNC_RELEASE: begin
                  if (bind_cnt[c] != 0) bind_cnt[c]--;
               end
               default: begin
                  bind_cnt[c] = '0;
               end
            endcase
         end
         push_rsp(ST_ACK, '0, 1'b1);
      endfunction

      task report(string msg);
         errors++;
         $display("%0t mismatch: %s", $time, msg);
      endtask

      task check_response(status_type s, core_type c, logic l);
         grant_rsp_type w;
         if (rsp_q.size() == 0) begin
            report($sformatf("response status=%0d core=%0d last=%0d with nothing pending",
                             s, c, l));
            return;
         end
         w = rsp_q.pop_front();
         if (s !== w.status) report($sformatf("status got %0d want %0d", s, w.status));
         if (c !== w.core_res) report($sformatf("core_res got %0d want %0d", c, w.core_res));
         if (l !== w.last) report($sformatf("last got %0d want %0d", l, w.last));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [6:0] csr_wdata;
   bit         calm;

   rca_req_if req_ch ();
   rca_rsp_if rsp_ch ();

   core_alloc_scoreboard sb = new();

   refcounted_core_allocator #(.MAX_CORES(CORE_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("refcounted_core_allocator test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.core_res, rsp_ch.last);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.func, req_ch.count, req_ch.core);
      end
   end

   // Response side: random stall bursts, long open stretches, none when calm.
   initial begin
      int pick;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (!calm && pick < 12) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else if (pick > 96) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(40, 200)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(func_type f, count_type want, core_type c);
      req_ch.valid <= 1'b1;
      req_ch.func  <= f;
      req_ch.count <= want;
      req_ch.core  <= c;
      do @(posedge clock); while (!req_ch.ready);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Hold off until every pending response is in and the sequencer is back to idle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_cores(count_type v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_cores(v);
   endtask

   task automatic random_item();
      int        lim;
      int        pick;
      func_type  f;
      count_type want;
      core_type  c;
      lim  = sb.active_limit();
      pick = $urandom_range(0, 99);
      if (pick < 35) f = FUNC_ALLOC;
      else if (pick < 65) f = FUNC_BIND;
      else if (pick < 85) f = FUNC_RELEASE;
      else f = FUNC_CLEAR;
      pick = $urandom_range(0, 9);
      if (f != FUNC_ALLOC || pick == 9) want = count_type'($urandom_range(0, 127));
      else if (pick < 7) want = count_type'($urandom_range(0, lim + 2));
      else want = count_type'($urandom_range(0, 3));
      if (lim > 0 && $urandom_range(0, 4) != 0) c = core_type'($urandom_range(0, lim - 1));
      else c = core_type'($urandom_range(0, 63));
      send_item(f, want, c);
   endtask

   initial begin
      count_type phase_cores [7];
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_ALLOC;
      req_ch.count = '0;
      req_ch.core  = '0;
      calm         = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, running on the reset value of cores_present.
      send_item(FUNC_ALLOC, 7'd0, 6'd0);
      send_item(FUNC_ALLOC, 7'd64, 6'd63);
      send_item(FUNC_ALLOC, 7'd65, 6'd0);
      send_item(FUNC_ALLOC, 7'd127, 6'd0);
      send_item(FUNC_BIND, 7'd127, 6'd0);
      send_item(FUNC_BIND, 7'd0, 6'd63);
      send_item(FUNC_BIND, 7'd0, 6'd5);
      send_item(FUNC_BIND, 7'd0, 6'd5);
      send_item(FUNC_ALLOC, 7'd61, 6'd0);
      send_item(FUNC_ALLOC, 7'd60, 6'd0);
      send_item(FUNC_RELEASE, 7'd0, 6'd5);
      send_item(FUNC_ALLOC, 7'd3, 6'd0);
      send_item(FUNC_RELEASE, 7'd0, 6'd5);
      send_item(FUNC_RELEASE, 7'd0, 6'd5);
      send_item(FUNC_CLEAR, 7'd0, 6'd63);
      send_item(FUNC_RELEASE, 7'd0, 6'd0);
      send_item(FUNC_ALLOC, 7'd64, 6'd0);

      // Small core set: out-of-range cores, then walk one count up and back past zero.
      write_cores(7'd8);
      send_item(FUNC_BIND, 7'd0, 6'd8);
      send_item(FUNC_BIND, 7'd0, 6'd63);
      send_item(FUNC_CLEAR, 7'd0, 6'd0);
      send_item(FUNC_ALLOC, 7'd8, 6'd0);
      send_item(FUNC_ALLOC, 7'd9, 6'd0);
      repeat (3) send_item(FUNC_BIND, 7'd0, 6'd7);
      send_item(FUNC_ALLOC, 7'd8, 6'd0);
      repeat (4) send_item(FUNC_RELEASE, 7'd0, 6'd7);
      send_item(FUNC_ALLOC, 7'd8, 6'd0);

      // Random part over several core counts, extremes included.
      phase_cores[0] = 7'd1;
      phase_cores[1] = 7'd127;
      phase_cores[2] = 7'd0;
      phase_cores[3] = 7'd65;
      phase_cores[4] = count_type'($urandom_range(2, 63));
      phase_cores[5] = count_type'($urandom_range(0, 127));
      phase_cores[6] = 7'd64;
      foreach (phase_cores[p]) begin
         write_cores(phase_cores[p]);
         if (p == 6) calm = 1'b1;
         repeat (10) random_item();
      end

      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("refcounted_core_allocator test passed");
      end else begin
         $display("refcounted_core_allocator test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/rca_pkg.sv
hdl/rca_req_if.sv
hdl/rca_rsp_if.sv
hdl/rca_ram.sv
hdl/refcounted_core_allocator.sv
tb/refcounted_core_allocator_tb.sv
